FILE: rtl/core/apss_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// apss_pkg: shared types and constants of the adaptive penalty step
// Item formats, configuration register indexes, reset values and the
// operation codes of the shared divide and square root unit.
// ----------------------------------------------------------------------------
package apss_pkg;

  localparam int unsigned VEC_LEN_DEF   = 1024;
  localparam int unsigned FRAC_BITS_DEF = 16;

  // width of the shift amount handed to the divider
  localparam int unsigned SH_W = 5;
  // operand width of the shared multiplier (magnitudes up to 2^32)
  localparam int unsigned MUL_W = 33;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_CORR_EPSILON   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CORR_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_LIMIT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_WEIGHT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_GAMMA   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_SCALE    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_START_WEIGHT   = 3'd6;

  localparam logic [31:0] CORR_EPSILON_RST   = 32'd1;
  localparam logic [16:0] CORR_THRESHOLD_RST = 17'd13107;
  localparam logic [31:0] SCALE_LIMIT_RST    = 32'd655360;
  localparam logic [31:0] START_WEIGHT_RST   = 32'd65536;

  typedef enum logic {
    OP_DIV  = 1'b0,
    OP_SQRT = 1'b1
  } apss_op_e;

  typedef struct packed {
    logic signed [31:0] dual_old;
    logic signed [31:0] dual_new;
    logic signed [31:0] split_val;
    logic signed [31:0] aux_val;
    logic               last_element;
  } apss_in_t;

  typedef struct packed {
    logic [31:0] new_weight;
    logic [17:0] new_gamma;
    logic        alpha_ok;
    logic        beta_ok;
    logic        saturated;
  } apss_out_t;

  // one word of the previous-pass store
  typedef struct packed {
    logic [31:0] yhat;
    logic [31:0] dual;
    logic [31:0] split;
    logic [31:0] aux;
  } apss_prev_t;

endpackage
`default_nettype wire

FILE: rtl/core/adaptive_penalty_spectral_step_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adaptive_penalty_spectral_step_top: spectral penalty weight update
// Stream solver vector elements, accumulate six difference dot products and
// emit a new penalty weight and relaxation gamma at the end of each pass.
// ----------------------------------------------------------------------------
// The block takes one element item at a time and is not ready while that
// item is at work. An element that does not end a pass runs from accept
// until ready rises again through one multiply for yhat, one step to form the
// differences and write the store, then six multiply and accumulate steps,
// each a multiply state and an accumulate state, on the shared multiplier.
// The element that ends a pass adds the scalar solve on the shared divide and
// square root unit: per test pair two square roots, a multiply, a check, and
// up to three divides, then up to one square root, two divides and three
// multiplies for the step and weight. The result item sits in an output
// register, so the next pass starts while it waits to be taken; a pass end
// only stalls in its output step while the previous result item is still
// waiting. After reset the store is swept to zero one entry a cycle, with
// ready held low; configuration writes are taken during the sweep.
module adaptive_penalty_spectral_step_top
  import apss_pkg::*;
#(
  parameter int unsigned VEC_LEN   = VEC_LEN_DEF,
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire apss_in_t              in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output apss_out_t                  out_data_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned IW = $clog2(VEC_LEN);
  localparam logic [IW-1:0] LAST_IDX = IW'(VEC_LEN - 1);

  localparam logic [31:0] ONE_W = 32'(64'd1 << FRAC_BITS);
  localparam logic [31:0] G_1P9 = 32'(((64'd19 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [31:0] G_1P1 = 32'(((64'd11 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [31:0] G_1P5 = 32'((64'd3 << FRAC_BITS) >> 1);
  localparam logic [31:0] G_2P0 = 32'(64'd2 << FRAC_BITS);
  localparam logic [SH_W-1:0] SH_CORR = SH_W'(16);
  localparam logic [SH_W-1:0] SH_FRAC = SH_W'(FRAC_BITS);

  typedef enum logic [21:0] {
    S_CLR   = 22'h000001,
    S_IDLE  = 22'h000002,
    S_YMUL  = 22'h000004,
    S_YHAT  = 22'h000008,
    S_ACCM  = 22'h000010,
    S_ACCA  = 22'h000020,
    S_SQX   = 22'h000040,
    S_SQY   = 22'h000080,
    S_NMUL  = 22'h000100,
    S_NCHK  = 22'h000200,
    S_CDIV  = 22'h000400,
    S_MGDIV = 22'h000800,
    S_SDDIV = 22'h001000,
    S_SEL   = 22'h002000,
    S_ABMUL = 22'h004000,
    S_ABSQ  = 22'h008000,
    S_GDIV  = 22'h010000,
    S_WM1   = 22'h020000,
    S_WM2   = 22'h040000,
    S_WCMP  = 22'h080000,
    S_WDIV  = 22'h100000,
    S_OUT   = 22'h200000
  } apss_state_e;

  function automatic logic [32:0] sext33(input logic [31:0] v);
    sext33 = {v[31], v};
  endfunction

  function automatic logic [32:0] mag33(input logic [32:0] v);
    mag33 = v[32] ? (33'd0 - v) : v;
  endfunction

  function automatic logic [31:0] cap32(input logic [63:0] v);
    cap32 = (|v[63:32]) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  // configuration and scalar state
  logic [31:0] eps_q, lim_cfg_q, w_q, gamma_q;
  logic [16:0] thr_q;
  logic        upw_q, upg_q, lims_q;

  apss_state_e    state_q, state_d;
  logic [IW-1:0]  clr_q, idx_q;
  apss_in_t       in_q;
  logic [32:0]    dh_q, dyh_q, dg_q, dy_q;
  logic           neg_q;
  logic [63:0]    sums_q [6];
  logic           sat_q;
  logic [2:0]     k_q;
  logic           p_q, pa_q, pb_q, go_q;
  logic [31:0]    rx_q, ry_q, a_q, b_q, mg_q, step_q, g_q, wn_q;
  logic [63:0]    lw_q;
  apss_out_t      out_q;
  logic           out_valid_q;

  logic           in_acc, out_go;

  // store
  logic              mem_we;
  logic [IW-1:0]     mem_waddr;
  apss_prev_t        mem_wdata, prev;
  logic [$bits(apss_prev_t)-1:0] mem_rdata;

  // shared multiplier
  logic             mul_en;
  logic [MUL_W-1:0] mul_a, mul_b;
  logic [2*MUL_W-1:0] prod_q;

  // shared divide and square root unit
  logic            it_start, it_busy, it_done, it_state;
  apss_op_e        it_op;
  logic [63:0]     it_num, it_den, it_res;
  logic [SH_W-1:0] it_sh;

  // element datapath
  logic [32:0] d_raw, d_mag;
  logic [65:0] t_mag;
  logic [66:0] yh_w;
  logic [31:0] yh_sat;
  logic [32:0] acc_x, acc_y;

  // accumulate
  logic [63:0] pv;
  logic        psat, ssat;
  logic [64:0] sum_w;
  logic [63:0] sum_new;

  // pass end
  logic [63:0] sx, sy, sxy, sxc, syc, eps64, n_val;
  logic        n_pass;
  logic [31:0] sd_cap, pair_step;
  logic [32:0] ab_sum;
  logic [31:0] lim, r_cap;
  logic [63:0] step_sh, w_sh;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_go     = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  apss_mem #(
    .DEPTH (VEC_LEN),
    .W     ($bits(apss_prev_t))
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (in_acc),
    .raddr_i (idx_q),
    .rdata_o (mem_rdata)
  );

  assign prev = apss_prev_t'(mem_rdata);

  apss_mul #(
    .W (MUL_W)
  ) u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod_q)
  );

  apss_iter #(
    .FRAC_BITS (FRAC_BITS)
  ) u_iter (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (it_start),
    .op_i    (it_op),
    .num_i   (it_num),
    .den_i   (it_den),
    .sh_i    (it_sh),
    .busy_o  (it_busy),
    .done_o  (it_done),
    .res_o   (it_res)
  );

  // --------------------------------------------------------------------------
  // Element arithmetic: yhat and the four differences
  // --------------------------------------------------------------------------
  always_comb begin
    d_raw = sext33(in_q.split_val) - sext33(in_q.aux_val);
    d_mag = mag33(d_raw);
    t_mag = prod_q >> FRAC_BITS;
    yh_w  = {{35{in_q.dual_old[31]}}, in_q.dual_old}
          + (d_raw[32] ? (67'd0 - {1'b0, t_mag}) : {1'b0, t_mag});
    // clamp yhat to signed 32 bit
    if ($signed(yh_w) > $signed(67'sh0_7FFF_FFFF)) begin
      yh_sat = 32'h7FFF_FFFF;
    end else if ($signed(yh_w) < -$signed(67'sh0_8000_0000)) begin
      yh_sat = 32'h8000_0000;
    end else begin
      yh_sat = yh_w[31:0];
    end
  end

  always_comb begin
    case (k_q)
      3'd0:    begin acc_x = dh_q;  acc_y = dh_q;  end
      3'd1:    begin acc_x = dyh_q; acc_y = dyh_q; end
      3'd2:    begin acc_x = dh_q;  acc_y = dyh_q; end
      3'd3:    begin acc_x = dg_q;  acc_y = dg_q;  end
      3'd4:    begin acc_x = dy_q;  acc_y = dy_q;  end
      3'd5:    begin acc_x = dg_q;  acc_y = dy_q;  end
      default: begin acc_x = dh_q;  acc_y = dh_q;  end
    endcase
  end

  // saturate the signed product, then the running sum
  always_comb begin
    psat = 1'b0;
    if (neg_q) begin
      if (|prod_q[65:63]) begin
        pv   = 64'h8000_0000_0000_0000;
        psat = (|prod_q[65:64]) || (|prod_q[62:0]);
      end else begin
        pv = 64'd0 - prod_q[63:0];
      end
    end else begin
      if (|prod_q[65:63]) begin
        pv   = 64'h7FFF_FFFF_FFFF_FFFF;
        psat = 1'b1;
      end else begin
        pv = prod_q[63:0];
      end
    end
    sum_w = {sums_q[0][63], sums_q[0]} + {pv[63], pv};
    ssat  = sum_w[64] != sum_w[63];
    if (ssat) begin
      sum_new = sum_w[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    end else begin
      sum_new = sum_w[63:0];
    end
  end

  // --------------------------------------------------------------------------
  // Pass end arithmetic
  // --------------------------------------------------------------------------
  always_comb begin
    sx    = p_q ? sums_q[3] : sums_q[0];
    sy    = p_q ? sums_q[4] : sums_q[1];
    sxy   = p_q ? sums_q[5] : sums_q[2];
    sxc   = sx[63] ? 64'd0 : sx;
    syc   = sy[63] ? 64'd0 : sy;
    eps64 = 64'(eps_q) << FRAC_BITS;
    n_val = prod_q[63:0];
    n_pass = ($signed(n_val) > $signed(eps64)) && ($signed(sxc) > $signed(eps64))
          && ($signed(sxy) > $signed(eps64));
    sd_cap = cap32(it_res);
    // step: mg when 2*mg > sd, else sd - mg/2
    if ({mg_q, 1'b0} > {1'b0, sd_cap}) begin
      pair_step = mg_q;
    end else begin
      pair_step = sd_cap - (mg_q >> 1);
    end
    ab_sum  = {1'b0, a_q} + {1'b0, b_q};
    lim     = (lim_cfg_q < ONE_W) ? ONE_W : lim_cfg_q;
    r_cap   = (it_res > 64'(ONE_W)) ? ONE_W : it_res[31:0];
    step_sh = 64'(step_q) << FRAC_BITS;
    w_sh    = 64'(w_q) << FRAC_BITS;
  end

  // --------------------------------------------------------------------------
  // Shared unit operand selection
  // --------------------------------------------------------------------------
  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    case (state_q)
      S_YMUL:  begin mul_en = 1'b1; mul_a = d_mag;             mul_b = {1'b0, w_q};    end
      S_ACCM:  begin mul_en = 1'b1; mul_a = mag33(acc_x);      mul_b = mag33(acc_y);   end
      S_NMUL:  begin mul_en = 1'b1; mul_a = {1'b0, rx_q};      mul_b = {1'b0, ry_q};   end
      S_ABMUL: begin mul_en = 1'b1; mul_a = {1'b0, a_q};       mul_b = {1'b0, b_q};    end
      S_WM1:   begin mul_en = 1'b1; mul_a = {1'b0, lim};       mul_b = {1'b0, w_q};    end
      S_WM2:   begin mul_en = 1'b1; mul_a = {1'b0, lim};       mul_b = {1'b0, step_q}; end
      default: begin mul_en = 1'b0; end
    endcase
  end

  always_comb begin
    it_state = 1'b1;
    it_op    = OP_DIV;
    it_num   = '0;
    it_den   = '0;
    it_sh    = SH_FRAC;
    case (state_q)
      S_SQX:   begin it_op = OP_SQRT; it_num = sxc; end
      S_SQY:   begin it_op = OP_SQRT; it_num = syc; end
      S_CDIV:  begin it_num = sxy; it_den = n_val; it_sh = SH_CORR; end
      S_MGDIV: begin it_num = sxy; it_den = sxc; end
      S_SDDIV: begin it_num = syc; it_den = sxy; end
      S_ABSQ:  begin it_op = OP_SQRT; it_num = n_val; end
      S_GDIV:  begin it_num = 64'({step_q, 1'b0}); it_den = 64'(ab_sum); end
      S_WDIV:  begin it_num = 64'(w_q); it_den = 64'(lim); end
      default: begin it_state = 1'b0; end
    endcase
  end

  assign it_start = it_state && !go_q;

  // store write: clearing sweep or write-back of the current element
  always_comb begin
    mem_we    = (state_q == S_CLR) || (state_q == S_YHAT);
    mem_waddr = (state_q == S_CLR) ? clr_q : idx_q;
    if (state_q == S_CLR) begin
      mem_wdata = '0;
    end else begin
      mem_wdata.yhat  = yh_sat;
      mem_wdata.dual  = in_q.dual_new;
      mem_wdata.split = in_q.split_val;
      mem_wdata.aux   = in_q.aux_val;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLR:   if (clr_q == LAST_IDX) state_d = S_IDLE;
      S_IDLE:  if (in_acc) state_d = S_YMUL;
      S_YMUL:  state_d = S_YHAT;
      S_YHAT:  state_d = S_ACCM;
      S_ACCM:  state_d = S_ACCA;
      S_ACCA: begin
        if (k_q == 3'd5) begin
          state_d = in_q.last_element ? S_SQX : S_IDLE;
        end else begin
          state_d = S_ACCM;
        end
      end
      S_SQX:   if (it_done) state_d = S_SQY;
      S_SQY:   if (it_done) state_d = S_NMUL;
      S_NMUL:  state_d = S_NCHK;
      S_NCHK: begin
        if (n_pass) begin
          state_d = S_CDIV;
        end else begin
          state_d = p_q ? S_SEL : S_SQX;
        end
      end
      S_CDIV: begin
        if (it_done) begin
          if (it_res <= 64'(thr_q)) begin
            state_d = p_q ? S_SEL : S_SQX;
          end else begin
            state_d = S_MGDIV;
          end
        end
      end
      S_MGDIV: if (it_done) state_d = S_SDDIV;
      S_SDDIV: if (it_done) state_d = p_q ? S_SEL : S_SQX;
      S_SEL:   state_d = (pa_q && pb_q) ? S_ABMUL : S_WM1;
      S_ABMUL: state_d = S_ABSQ;
      S_ABSQ:  if (it_done) state_d = (ab_sum == 33'd0) ? S_WM1 : S_GDIV;
      S_GDIV:  if (it_done) state_d = S_WM1;
      S_WM1:   state_d = upw_q ? S_WM2 : S_OUT;
      S_WM2:   state_d = S_WCMP;
      S_WCMP: begin
        if (lims_q && (step_sh > lw_q)) begin
          state_d = S_OUT;
        end else if (lims_q && (prod_q[63:0] < w_sh)) begin
          state_d = S_WDIV;
        end else begin
          state_d = S_OUT;
        end
      end
      S_WDIV:  if (it_done) state_d = S_OUT;
      S_OUT:   if (out_go) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      idx_q       <= '0;
      k_q         <= '0;
      p_q         <= 1'b0;
      pa_q        <= 1'b0;
      pb_q        <= 1'b0;
      go_q        <= 1'b0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        sums_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      // track the running op of the shared unit
      if (it_start) begin
        go_q <= 1'b1;
      end else if (it_done) begin
        go_q <= 1'b0;
      end
      // load a new result item, or drop the one just taken
      if (out_go) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLR: begin
          clr_q <= clr_q + IW'(1);
        end
        S_ACCA: begin
          // rotate so the sum in work always sits in slot 0
          for (int i = 0; i < 5; i++) begin
            sums_q[i] <= sums_q[i+1];
          end
          sums_q[5] <= sum_new;
          sat_q     <= sat_q | psat | ssat;
          if (k_q == 3'd5) begin
            k_q <= '0;
            p_q <= 1'b0;
            if (!in_q.last_element) begin
              idx_q <= (idx_q == LAST_IDX) ? '0 : idx_q + IW'(1);
            end
          end else begin
            k_q <= k_q + 3'd1;
          end
        end
        S_NCHK: begin
          if (!n_pass) begin
            if (p_q) pb_q <= 1'b0;
            else     pa_q <= 1'b0;
            p_q <= 1'b1;
          end
        end
        S_CDIV: begin
          if (it_done && it_res <= 64'(thr_q)) begin
            if (p_q) pb_q <= 1'b0;
            else     pa_q <= 1'b0;
            p_q <= 1'b1;
          end
        end
        S_SDDIV: begin
          if (it_done) begin
            if (p_q) pb_q <= 1'b1;
            else     pa_q <= 1'b1;
            p_q <= 1'b1;
          end
        end
        S_OUT: begin
          if (out_go) begin
            sat_q       <= 1'b0;
            idx_q       <= '0;
            for (int i = 0; i < 6; i++) begin
              sums_q[i] <= '0;
            end
          end
        end
        default: begin
          sat_q <= sat_q;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q <= in_data_i;
    end
    case (state_q)
      S_YHAT: begin
        dyh_q <= sext33(yh_sat) - sext33(prev.yhat);
        dy_q  <= sext33(prev.dual) - sext33(in_q.dual_new);
        dh_q  <= sext33(in_q.split_val) - sext33(prev.split);
        dg_q  <= sext33(prev.aux) - sext33(in_q.aux_val);
      end
      S_ACCM: begin
        neg_q <= acc_x[32] ^ acc_y[32];
      end
      S_SQX: begin
        if (it_done) rx_q <= it_res[31:0];
      end
      S_SQY: begin
        if (it_done) ry_q <= it_res[31:0];
      end
      S_MGDIV: begin
        if (it_done) mg_q <= cap32(it_res);
      end
      S_SDDIV: begin
        if (it_done) begin
          if (p_q) b_q <= pair_step;
          else     a_q <= pair_step;
        end
      end
      S_SEL: begin
        if (pa_q && !pb_q) begin
          step_q <= a_q;
          g_q    <= G_1P9;
        end else if (pb_q && !pa_q) begin
          step_q <= b_q;
          g_q    <= G_1P1;
        end else if (!pa_q && !pb_q) begin
          step_q <= w_q;
          g_q    <= G_1P5;
        end
      end
      S_ABSQ: begin
        if (it_done) begin
          step_q <= it_res[31:0];
          g_q    <= G_2P0;
        end
      end
      S_GDIV: begin
        if (it_done) g_q <= ONE_W + r_cap;
      end
      S_WM1: begin
        wn_q <= w_q;
      end
      S_WM2: begin
        lw_q <= prod_q[63:0];
      end
      S_WCMP: begin
        if (lims_q && (step_sh > lw_q)) begin
          wn_q <= cap32(lw_q >> FRAC_BITS);
        end else if (!(lims_q && (prod_q[63:0] < w_sh))) begin
          wn_q <= step_q;
        end
      end
      S_WDIV: begin
        if (it_done) wn_q <= cap32(it_res);
      end
      S_OUT: begin
        if (out_go) begin
          out_q.new_weight <= wn_q;
          out_q.new_gamma  <= upg_q ? g_q[17:0] : gamma_q[17:0];
          out_q.alpha_ok   <= pa_q;
          out_q.beta_ok    <= pb_q;
          out_q.saturated  <= sat_q;
        end
      end
      default: begin
        neg_q <= neg_q;
      end
    endcase
  end

  // configuration registers, weight and gamma
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q     <= CORR_EPSILON_RST;
      thr_q     <= CORR_THRESHOLD_RST;
      lim_cfg_q <= SCALE_LIMIT_RST;
      upw_q     <= 1'b1;
      upg_q     <= 1'b1;
      lims_q    <= 1'b1;
      w_q       <= START_WEIGHT_RST;
      gamma_q   <= G_1P5;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_CORR_EPSILON:   eps_q     <= cfg_wdata_i;
          CFG_CORR_THRESHOLD: thr_q     <= cfg_wdata_i[16:0];
          CFG_SCALE_LIMIT:    lim_cfg_q <= cfg_wdata_i;
          CFG_UPDATE_WEIGHT:  upw_q     <= cfg_wdata_i[0];
          CFG_UPDATE_GAMMA:   upg_q     <= cfg_wdata_i[0];
          CFG_LIMIT_SCALE:    lims_q    <= cfg_wdata_i[0];
          CFG_START_WEIGHT:   w_q       <= cfg_wdata_i;
          default:            eps_q     <= eps_q;
        endcase
      end else if (out_go) begin
        // commit the pass result
        w_q <= wn_q;
        if (upg_q) gamma_q <= g_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o)
    else $error("ready high right after an accepted item");

  a_start_idle_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    it_start |-> !it_busy)
    else $error("shared unit started while busy");

  a_result_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_OUT))
    else $error("result item raised outside the output step");

endmodule
`default_nettype wire

FILE: rtl/core/apss_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// apss_mem: previous-pass store
// One write port and one registered read port.
// ----------------------------------------------------------------------------
module apss_mem
  import apss_pkg::*;
#(
  parameter int unsigned DEPTH = VEC_LEN_DEF,
  parameter int unsigned W     = $bits(apss_prev_t)
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [W-1:0]             wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [W-1:0]             rdata_o
);

  logic [W-1:0] mem_q [DEPTH];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rdata_q <= '0;
    end else if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: rtl/core/apss_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// apss_mul: shared magnitude multiplier
// Unsigned product with a registered result; hold the result while idle.
// ----------------------------------------------------------------------------
module apss_mul
  import apss_pkg::*;
#(
  parameter int unsigned W = MUL_W
) (
  input  wire logic           clk_i,
  input  wire logic           en_i,
  input  wire logic [W-1:0]   a_i,
  input  wire logic [W-1:0]   b_i,
  output logic      [2*W-1:0] prod_o
);

  logic [2*W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= (2*W)'(a_i) * (2*W)'(b_i);
    end
  end

  assign prod_o = prod_q;

endmodule
`default_nettype wire

FILE: rtl/core/apss_iter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// apss_iter: shared divide and square root unit
// Restoring divide one quotient bit a cycle, saturated to 64 bits, or
// integer square root of a 64-bit value two bits a cycle.
// ----------------------------------------------------------------------------
module apss_iter
  import apss_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire apss_op_e        op_i,
  input  wire logic [63:0]     num_i,
  input  wire logic [63:0]     den_i,
  input  wire logic [SH_W-1:0] sh_i,
  output logic                 busy_o,
  output logic                 done_o,
  output logic      [63:0]     res_o
);

  localparam int unsigned SHM = (FRAC_BITS > 16) ? FRAC_BITS : 16;
  localparam int unsigned DW  = 64 + SHM;
  localparam int unsigned CW  = $clog2(DW + 1);

  apss_op_e       op_q;
  logic           busy_q, done_q;
  logic [CW-1:0]  cnt_q;
  logic [DW-1:0]  acc_q;
  logic [63:0]    rem_q, den_q, bit_q;

  logic [64:0]    rem_sh, rem_sub;
  logic           rem_ge;
  logic [63:0]    trial;
  logic           sq_ge;

  always_comb begin
    rem_sh  = {rem_q, acc_q[DW-1]};
    rem_ge  = rem_sh >= {1'b0, den_q};
    rem_sub = rem_sh - {1'b0, den_q};
    trial   = acc_q[63:0] + bit_q;
    sq_ge   = rem_q >= trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= OP_DIV;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        op_q   <= op_i;
        cnt_q  <= (op_i == OP_DIV) ? CW'(DW) : CW'(32);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      bit_q <= 64'd1 << 62;
      if (op_i == OP_DIV) begin
        acc_q <= DW'(num_i) << sh_i;
        rem_q <= '0;
      end else begin
        acc_q <= '0;
        rem_q <= num_i;
      end
    end else if (busy_q) begin
      case (op_q)
        OP_DIV: begin
          rem_q <= rem_ge ? rem_sub[63:0] : rem_sh[63:0];
          acc_q <= {acc_q[DW-2:0], rem_ge};
        end
        OP_SQRT: begin
          if (sq_ge) begin
            rem_q <= rem_q - trial;
            acc_q <= DW'((acc_q[63:0] >> 1) + bit_q);
          end else begin
            acc_q <= DW'(acc_q[63:0] >> 1);
          end
          bit_q <= bit_q >> 2;
        end
        default: begin
          acc_q <= acc_q;
        end
      endcase
    end
  end

  always_comb begin
    if (op_q == OP_DIV && (|acc_q[DW-1:64])) begin
      res_o = '1;
    end else begin
      res_o = acc_q[63:0];
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;

endmodule
`default_nettype wire
